// File: hdl/bmpc_pkg.sv
// Shared types and constants for the BMP 24-bit to RGB565 framebuffer writer.
// Used by the front parser, the request queue and the back-end formatter.
`timescale 1ns / 1ps

package bmpc_pkg;

    localparam int ADDR_W      = 17;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] BMP_SIGNATURE   = 16'h4D42;
    localparam logic [31:0] MIN_HEADER_SIZE = 32'd40;
    localparam logic [15:0] BMP_DEPTH       = 16'd24;
    localparam logic [15:0] BMP_PLANES      = 16'd1;
    localparam logic [32:0] FILE_HDR_BYTES  = 33'd14;

    // header byte positions where a field completes
    localparam logic [31:0] POS_SIG      = 32'd1;
    localparam logic [31:0] POS_OFFSET   = 32'd13;
    localparam logic [31:0] POS_HDR_SIZE = 32'd17;
    localparam logic [31:0] POS_WIDTH    = 32'd21;
    localparam logic [31:0] POS_HEIGHT   = 32'd25;
    localparam logic [31:0] POS_PLANES   = 32'd27;
    localparam logic [31:0] POS_DEPTH    = 32'd29;
    localparam logic [31:0] POS_COMPRESS = 32'd33;
    // header byte positions used to stage the crop geometry
    localparam logic [31:0] POS_GEOM      = 32'd26;
    localparam logic [31:0] POS_ROW0      = 32'd27;
    localparam logic [31:0] POS_BASE_MULT = 32'd28;
    localparam logic [31:0] POS_BASE_ADJ  = 32'd29;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_GAP,
        PH_IMAGE,
        PH_DONE,
        PH_BAD
    } phase_t;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_TRUNCATED  = 2'd2;

    typedef struct packed {
        logic              write;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        blue;
        logic [7:0]        green;
        logic [7:0]        red;
        logic              done;
        logic [1:0]        status;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [15:0] rgb565(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

// File: hdl/bmpc_queue.sv
// Short request queue between the front parser and the back-end formatter.
// Depends on bmpc_pkg for the entry type and depth.
`timescale 1ns / 1ps

module bmpc_queue
    import bmpc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  q_entry_t  push_data,
    input  logic      pop,
    output q_entry_t  pop_data,
    output q_status_t stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push) begin
            tail_next = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (pop) begin
            head_next = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[tail_reg] <= push_data;
        end
    end

    assign pop_data   = slot_reg[head_reg];
    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// File: hdl/bmpc_front.sv
// Front end: accepts file bytes, parses and checks the BMP header, tracks rows,
// columns and crop window, and queues one request per pixel write or end of file.
// Depends on bmpc_pkg.
`timescale 1ns / 1ps

module bmpc_front
    import bmpc_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 320
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic [7:0] s_tdata,
    input  logic      s_tlast,
    input  q_status_t q_stat,
    output logic      q_push,
    output q_entry_t  q_data
);

    localparam int RW = $clog2(SCREEN_HEIGHT + 1);
    localparam int CW = $clog2(SCREEN_WIDTH + 1);
    localparam logic [31:0]       SW32 = 32'(SCREEN_WIDTH);
    localparam logic [31:0]       SH32 = 32'(SCREEN_HEIGHT);
    localparam logic [ADDR_W-1:0] SW_A = ADDR_W'(SCREEN_WIDTH);

    phase_t      phase_reg, phase_next, phase_work;
    logic        accept;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] shift_reg, hdr_word;
    logic [31:0] offset_reg, width_reg, height_reg, row_bytes_reg;
    logic        bottom_up_reg;
    logic [RW-1:0] dh_reg, dy_reg, row0_reg, rows_reg;
    logic [CW-1:0] dw_reg, dx_reg;
    logic [31:0] sy_reg, sx_reg, sx_end_reg, skip_bu_reg, skip_reg;
    logic [31:0] bir_reg, col_reg;
    logic [1:0]  comp_reg;
    logic [7:0]  blue_reg, green_reg;
    logic [ADDR_W-1:0] base_reg;

    logic [33:0] width_x3;
    logic [31:0] row0_prod;
    logic        hdr_fail, in_image, draw, row_end, frame_end, pixel;
    logic [RW:0] rows_inc;
    logic [1:0]  status_code;

    assign hdr_word  = {s_tdata, shift_reg[31:8]};
    assign width_x3  = {2'b00, hdr_word} + {1'b0, hdr_word, 1'b0} + 34'd3;
    assign row0_prod = 32'(row0_reg) * SW32;

    // header field checks, valid only while the header is being parsed
    always_comb begin
        hdr_fail = 1'b0;
        case (pos_reg)
            POS_SIG:      hdr_fail = (hdr_word[31:16] != BMP_SIGNATURE);
            POS_HDR_SIZE: hdr_fail = (hdr_word < MIN_HEADER_SIZE) ||
                                     ({1'b0, offset_reg} < FILE_HDR_BYTES + {1'b0, hdr_word});
            POS_WIDTH:    hdr_fail = (hdr_word == '0) || hdr_word[31] ||
                                     (width_x3[33:32] != 2'b00);
            POS_HEIGHT:   hdr_fail = (hdr_word == '0);
            POS_PLANES:   hdr_fail = (hdr_word[31:16] != BMP_PLANES);
            POS_DEPTH:    hdr_fail = (hdr_word[31:16] != BMP_DEPTH);
            POS_COMPRESS: hdr_fail = (hdr_word != '0);
            default:      hdr_fail = 1'b0;
        endcase
    end

    assign in_image  = (phase_reg == PH_IMAGE) ||
                       ((phase_reg == PH_GAP) && (pos_reg >= offset_reg));
    assign draw      = (skip_reg == '0);
    assign row_end   = in_image && ((bir_reg + 32'd1) >= row_bytes_reg);
    assign rows_inc  = {1'b0, rows_reg} + 1'b1;
    assign frame_end = row_end && draw && (rows_inc >= {1'b0, dh_reg});
    assign pixel     = in_image && draw && (comp_reg == 2'd2) &&
                       (col_reg >= sx_reg) && (col_reg < sx_end_reg);

    // next state
    always_comb begin
        case (phase_reg)
            PH_HEADER: begin
                if (hdr_fail)                     phase_work = PH_BAD;
                else if (pos_reg == POS_COMPRESS) phase_work = PH_GAP;
                else                              phase_work = PH_HEADER;
            end
            PH_GAP, PH_IMAGE: begin
                if (frame_end)     phase_work = PH_DONE;
                else if (in_image) phase_work = PH_IMAGE;
                else               phase_work = phase_reg;
            end
            default: phase_work = phase_reg;
        endcase
        if (!accept)      phase_next = phase_reg;
        else if (s_tlast) phase_next = PH_HEADER;
        else              phase_next = phase_work;
    end

    // outputs
    always_comb begin
        s_tready = !q_stat.full;
        accept   = s_tvalid && s_tready;
        q_push   = accept && (pixel || s_tlast);
        if (phase_work inside {PH_HEADER, PH_BAD}) status_code = ST_BAD_HEADER;
        else if (phase_work == PH_DONE)             status_code = ST_OK;
        else                                        status_code = ST_TRUNCATED;
        q_data.write  = pixel;
        q_data.addr   = pixel ? base_reg + col_reg[ADDR_W-1:0] : '0;
        q_data.blue   = blue_reg;
        q_data.green  = green_reg;
        q_data.red    = s_tdata;
        q_data.done   = s_tlast;
        q_data.status = s_tlast ? status_code : ST_OK;
    end

    always_comb begin
        pos_next = pos_reg;
        if (accept) begin
            if (s_tlast)              pos_next = '0;
            else if (pos_reg != '1)   pos_next = pos_reg + 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
    end

    // payload: header fields, staged crop geometry, row/column tracking
    always_ff @(posedge aclk) begin
        if (accept) begin
            shift_reg <= hdr_word;
            if (phase_reg == PH_HEADER) begin
                case (pos_reg)
                    POS_OFFSET: offset_reg <= hdr_word;
                    POS_WIDTH: begin
                        width_reg     <= hdr_word;
                        row_bytes_reg <= {width_x3[31:2], 2'b00};
                    end
                    POS_HEIGHT: begin
                        bottom_up_reg <= !hdr_word[31];
                        height_reg    <= hdr_word[31] ? 32'd0 - hdr_word : hdr_word;
                    end
                    POS_GEOM: begin
                        dh_reg <= (height_reg > SH32) ? RW'(SCREEN_HEIGHT) : height_reg[RW-1:0];
                        sy_reg <= (height_reg > SH32) ? (height_reg - SH32) >> 1 : '0;
                        dy_reg <= (height_reg < SH32) ? RW'((SH32 - height_reg) >> 1) : '0;
                        dw_reg <= (width_reg > SW32) ? CW'(SCREEN_WIDTH) : width_reg[CW-1:0];
                        sx_reg <= (width_reg > SW32) ? (width_reg - SW32) >> 1 : '0;
                        dx_reg <= (width_reg < SW32) ? CW'((SW32 - width_reg) >> 1) : '0;
                    end
                    POS_ROW0: begin
                        // first drawn row sits at the bottom for bottom-up files
                        row0_reg    <= dy_reg + (bottom_up_reg ? dh_reg - 1'b1 : '0);
                        sx_end_reg  <= sx_reg + 32'(dw_reg);
                        skip_bu_reg <= height_reg - sy_reg - 32'(dh_reg);
                    end
                    POS_BASE_MULT: base_reg <= row0_prod[ADDR_W-1:0];
                    POS_BASE_ADJ:  base_reg <= base_reg + ADDR_W'(dx_reg) - sx_reg[ADDR_W-1:0];
                    POS_COMPRESS: begin
                        skip_reg <= bottom_up_reg ? skip_bu_reg : sy_reg;
                        bir_reg  <= '0;
                        col_reg  <= '0;
                        comp_reg <= '0;
                        rows_reg <= '0;
                    end
                    default: ;
                endcase
            end else if (in_image) begin
                if (draw && comp_reg == 2'd0) blue_reg  <= s_tdata;
                if (draw && comp_reg == 2'd1) green_reg <= s_tdata;
                if (row_end) begin
                    bir_reg  <= '0;
                    col_reg  <= '0;
                    comp_reg <= '0;
                    if (!draw) begin
                        skip_reg <= skip_reg - 32'd1;
                    end else begin
                        rows_reg <= rows_inc[RW-1:0];
                        base_reg <= bottom_up_reg ? base_reg - SW_A : base_reg + SW_A;
                    end
                end else begin
                    bir_reg <= bir_reg + 32'd1;
                    if (comp_reg == 2'd2) begin
                        comp_reg <= '0;
                        col_reg  <= col_reg + 32'd1;
                    end else begin
                        comp_reg <= comp_reg + 2'd1;
                    end
                end
            end
        end
    end

endmodule

// File: hdl/bmpc_back.sv
// Back end: takes queued requests, packs RGB565 color and drives the result
// register toward the framebuffer side. Depends on bmpc_pkg.
`timescale 1ns / 1ps

module bmpc_back
    import bmpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  q_status_t   q_stat,
    input  q_entry_t    q_data,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    logic        valid_reg, valid_next;
    logic [39:0] data_reg;
    logic        user_reg, last_reg;
    logic [15:0] color;

    assign q_pop = !q_stat.empty && (!valid_reg || m_tready);
    assign color = q_data.write ? rgb565(q_data.red, q_data.green, q_data.blue) : 16'd0;

    always_comb begin
        valid_next = valid_reg;
        if (q_pop)         valid_next = 1'b1;
        else if (m_tready) valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else          valid_reg <= valid_next;
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= {5'd0, q_data.status, color, q_data.addr};
            user_reg <= q_data.write;
            last_reg <= q_data.done;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

// File: hdl/bmp24_crop_to_rgb565_writer_top.sv
// BMP 24-bit to RGB565 framebuffer writer, top level: front parser, request queue, back end.
// Throughput: one file byte per cycle while the queue is not full; the per-byte front update sets it.
// Path: a pixel write or end-of-file report is written into the queue when its byte is taken,
// then moved into the result register toward m_; it is held back while m_tready is low.
// Reset: synchronous aresetn clears parse phase, byte count, queue pointers and result valid.
`timescale 1ns / 1ps

module bmp24_crop_to_rgb565_writer_top
    import bmpc_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 320
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pixel_address[16:0], pixel_color[32:17], status[34:33]
    output logic        m_tuser,   // write_valid
    output logic        m_tlast    // done_res
);

    q_status_t q_stat;
    q_entry_t  push_data, pop_data;
    logic      q_push, q_pop;

    bmpc_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    bmpc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    bmpc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .q_data   (pop_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("request pushed into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("request popped from empty queue");

    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser || m_tlast))
        else $error("result with neither pixel write nor done");

    a_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[32:0] == 33'd0))
        else $error("non-write result carries address or color");

endmodule
